// ----- rtl/mpt_pkg.sv -----
// Shared types and constants for the mouse packet pointer tracker.
// No dependencies; imported by mpt_step, mouse_packet_pointer_tracker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

  localparam int SIZE_W = 13;   // screen size register width
  localparam int PTR_W  = 12;   // pointer fields of a result
  localparam int ABS_W  = 16;   // absolute report coordinates

  localparam int SCREEN_WIDTH_RESET  = 640;
  localparam int SCREEN_HEIGHT_RESET = 480;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    ACT_PS2      = 2'd0,
    ACT_SERIAL   = 2'd1,
    ACT_ABS      = 2'd2,
    ACT_RECENTER = 2'd3
  } mpt_action_t;

  typedef enum logic [1:0] {
    EV_MOVE       = 2'd0,
    EV_LEFT_DOWN  = 2'd1,
    EV_LEFT_UP    = 2'd2,
    EV_RIGHT_DOWN = 2'd3
  } mpt_event_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  typedef struct packed {
    mpt_action_t        action;
    logic [7:0]         data_byte;
    logic [ABS_W-1:0]   abs_x;
    logic [ABS_W-1:0]   abs_y;
    logic               abs_left;
    logic               abs_right;
  } mpt_item_t;

  typedef struct packed {
    mpt_event_t         event_kind;
    logic [PTR_W-1:0]   pos_x;
    logic [PTR_W-1:0]   pos_y;
  } mpt_result_t;

  // Button and packet assembler state.
  typedef struct packed {
    logic       left_held;
    logic       right_held;
    logic [1:0] ps2_count;
    logic [1:0] serial_count;
  } mpt_ctrl_t;

  // Write strobes for the two stored bytes of each assembler.
  typedef struct packed {
    logic ps2_we;
    logic serial_we;
    logic idx;
  } mpt_wr_t;

endpackage

`default_nettype wire

// ----- rtl/mpt_step.sv -----
// Next-state and result logic for one accepted item of the pointer tracker.
// Depends on mpt_pkg for item, result and control types.
`timescale 1ns / 1ps
`default_nettype none

module mpt_step import mpt_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  mpt_item_t              item,
  input  mpt_ctrl_t              ctrl,
  input  logic [COORD_BITS-1:0]  cursor_x,
  input  logic [COORD_BITS-1:0]  cursor_y,
  input  logic [1:0][7:0]        ps2_bytes,
  input  logic [1:0][7:0]        serial_bytes,
  input  logic [SIZE_W-1:0]      screen_width,
  input  logic [SIZE_W-1:0]      screen_height,
  output mpt_ctrl_t              ctrl_next,
  output logic [COORD_BITS-1:0]  cursor_x_next,
  output logic [COORD_BITS-1:0]  cursor_y_next,
  output mpt_wr_t                byte_wr,
  output logic                   has_result,
  output mpt_result_t            result
);

  localparam int V_W   = 18;
  localparam int LIM_W = 16;
  localparam logic [LIM_W-1:0] COORD_MAX = LIM_W'((1 << COORD_BITS) - 1);

  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [V_W-1:0] v,
    input logic [SIZE_W-1:0]     size
  );
    logic [LIM_W-1:0] lim;
    logic [V_W-1:0]   res;
    lim = (size == '0) ? '0 : LIM_W'(size - SIZE_W'(1));
    if (lim > COORD_MAX) lim = COORD_MAX;
    if (v[V_W-1]) res = '0;
    else if (V_W'(v) > V_W'(lim)) res = V_W'(lim);
    else res = V_W'(v);
    return COORD_BITS'(res);
  endfunction

  function automatic logic [COORD_BITS-1:0] half_coord(input logic [SIZE_W-1:0] size);
    logic [LIM_W-1:0] h;
    h = LIM_W'(size >> 1);
    if (h > COORD_MAX) h = COORD_MAX;
    return COORD_BITS'(h);
  endfunction

  logic signed [V_W-1:0] cx_ext, cy_ext;
  logic signed [V_W-1:0] ps2_dx, ps2_dy, ser_dx, ser_dy, abs_xe, abs_ye;
  logic [7:0]            ser_x_raw, ser_y_raw;
  logic [1:0]            ser_count;

  logic                  report;
  logic signed [V_W-1:0] rep_x, rep_y;
  logic                  rep_left, rep_right;
  logic [COORD_BITS-1:0] new_x, new_y;
  mpt_event_t            kind;

  assign cx_ext = signed'({{(V_W-COORD_BITS){1'b0}}, cursor_x});
  assign cy_ext = signed'({{(V_W-COORD_BITS){1'b0}}, cursor_y});

  // PS/2 deltas are 9-bit two's complement with the sign in the status byte.
  assign ps2_dx = signed'({{(V_W-8){ps2_bytes[0][4]}}, ps2_bytes[1]});
  assign ps2_dy = signed'({{(V_W-8){ps2_bytes[0][5]}}, item.data_byte});

  // Serial deltas carry their top two bits in the first byte of the packet.
  assign ser_x_raw = {serial_bytes[0][1:0], serial_bytes[1][5:0]};
  assign ser_y_raw = {serial_bytes[0][3:2], item.data_byte[5:0]};
  assign ser_dx    = signed'({{(V_W-8){ser_x_raw[7]}}, ser_x_raw});
  assign ser_dy    = signed'({{(V_W-8){ser_y_raw[7]}}, ser_y_raw});

  assign abs_xe = signed'({{(V_W-ABS_W){item.abs_x[ABS_W-1]}}, item.abs_x});
  assign abs_ye = signed'({{(V_W-ABS_W){item.abs_y[ABS_W-1]}}, item.abs_y});

  // A serial byte with bit 6 set always restarts the packet.
  assign ser_count = item.data_byte[6] ? 2'd0 : ctrl.serial_count;

  always_comb begin
    ctrl_next     = ctrl;
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    byte_wr       = '0;
    report        = 1'b0;
    rep_x         = '0;
    rep_y         = '0;
    rep_left      = 1'b0;
    rep_right     = 1'b0;

    case (item.action)
      ACT_PS2: begin
        if (ctrl.ps2_count == 2'd0 && !item.data_byte[3]) begin
          // Out of sync: wait for a byte that can open a packet.
        end else if (ctrl.ps2_count < 2'd2) begin
          byte_wr.ps2_we      = 1'b1;
          byte_wr.idx         = ctrl.ps2_count[0];
          ctrl_next.ps2_count = ctrl.ps2_count + 2'd1;
        end else begin
          ctrl_next.ps2_count = 2'd0;
          // Packets with either overflow bit are dropped.
          if (ps2_bytes[0][7:6] == 2'b00) begin
            report    = 1'b1;
            rep_x     = cx_ext + ps2_dx;
            rep_y     = cy_ext - ps2_dy;
            rep_left  = ps2_bytes[0][0];
            rep_right = ps2_bytes[0][1];
          end
        end
      end
      ACT_SERIAL: begin
        ctrl_next.serial_count = ser_count;
        if (!item.data_byte[6] && ser_count == 2'd0) begin
          // Continuation byte with no packet open.
        end else if (ser_count < 2'd2) begin
          byte_wr.serial_we      = 1'b1;
          byte_wr.idx            = ser_count[0];
          ctrl_next.serial_count = ser_count + 2'd1;
        end else begin
          ctrl_next.serial_count = 2'd0;
          report    = 1'b1;
          rep_x     = cx_ext + ser_dx;
          rep_y     = cy_ext + ser_dy;
          rep_left  = serial_bytes[0][5];
          rep_right = serial_bytes[0][4];
        end
      end
      ACT_ABS: begin
        report    = 1'b1;
        rep_x     = abs_xe;
        rep_y     = abs_ye;
        rep_left  = item.abs_left;
        rep_right = item.abs_right;
      end
      ACT_RECENTER: begin
        cursor_x_next = half_coord(screen_width);
        cursor_y_next = half_coord(screen_height);
      end
      default: begin
      end
    endcase

    new_x = clamp_coord(rep_x, screen_width);
    new_y = clamp_coord(rep_y, screen_height);

    if (rep_left && !ctrl.left_held) kind = EV_LEFT_DOWN;
    else if (!rep_left && ctrl.left_held) kind = EV_LEFT_UP;
    else if (rep_right && !ctrl.right_held) kind = EV_RIGHT_DOWN;
    else kind = EV_MOVE;

    has_result = 1'b0;
    if (report) begin
      cursor_x_next        = new_x;
      cursor_y_next        = new_y;
      ctrl_next.left_held  = rep_left;
      ctrl_next.right_held = rep_right;
      has_result = (kind != EV_MOVE) || (new_x != cursor_x) || (new_y != cursor_y);
    end

    result.event_kind = kind;
    result.pos_x      = PTR_W'(new_x);
    result.pos_y      = PTR_W'(new_y);
  end

endmodule

`default_nettype wire

// ----- rtl/mouse_packet_pointer_tracker.sv -----
// Top level of the mouse packet pointer tracker: stream ports, state and result register.
// Depends on mpt_pkg and mpt_step.
`timescale 1ns / 1ps
`default_nettype none

// The tracker takes one request per clock cycle on the slave stream: a PS/2 mouse
// byte, a serial mouse byte, an absolute pointer report or a recenter command, chosen
// by s_tuser. Each request is captured in an input register, from which a single pass
// of logic assembles packets, clamps the pointer to the screen and writes at most one
// result into the output register. Sustained throughput is one request per cycle; the
// only stall comes from the output register, which holds a result until m_tready takes
// it, and only a request that produces a result waits for it.
// Requests that give no result (partial packets, dropped PS/2 packets, recenter, or
// a move that leaves the pointer where it was) still update the state and never
// stall. The screen size registers are written through the cfg channel, which is
// always ready; they should be changed only while the tracker is idle, and new
// values apply from the next packet on without moving the pointer. After reset the
// pointer sits at the middle of a 640 by 480 screen.

module mouse_packet_pointer_tracker import mpt_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [7:0] data_byte, [23:8] abs_x, [39:24] abs_y, [40] abs_left, [41] abs_right,
  // [47:42] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] action
  input  logic [1:0]            s_tuser,

  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [11:0] pos_x, [23:12] pos_y
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [1:0] event_kind
  output logic [1:0]            m_tuser,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  localparam int CMAX   = (1 << COORD_BITS) - 1;
  localparam int HALF_W = SCREEN_WIDTH_RESET / 2;
  localparam int HALF_H = SCREEN_HEIGHT_RESET / 2;
  localparam logic [COORD_BITS-1:0] CURSOR_X_RESET = COORD_BITS'((HALF_W > CMAX) ? CMAX : HALF_W);
  localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET = COORD_BITS'((HALF_H > CMAX) ? CMAX : HALF_H);

  // Configuration registers.
  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;

  // Tracker state.
  logic [COORD_BITS-1:0] cursor_x, cursor_y;
  mpt_ctrl_t             ctrl;
  logic [1:0][7:0]       ps2_bytes;
  logic [1:0][7:0]       serial_bytes;

  // Input register.
  logic      in_valid;
  mpt_item_t in_item;

  // Output register.
  mpt_result_t out_res;

  // Step logic outputs.
  mpt_ctrl_t             ctrl_next;
  logic [COORD_BITS-1:0] cursor_x_next, cursor_y_next;
  mpt_wr_t               byte_wr;
  logic                  step_has_result;
  mpt_result_t           step_result;

  logic out_free;
  logic in_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SIZE_W'(SCREEN_WIDTH_RESET);
      screen_height <= SIZE_W'(SCREEN_HEIGHT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The input stage moves on whenever its request yields no result, or the
  // output register is empty or being emptied in this cycle.
  assign out_free = !m_tvalid || m_tready;
  assign in_adv   = in_valid && (!step_has_result || out_free);
  assign s_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action    <= mpt_action_t'(s_tuser);
      in_item.data_byte <= s_tdata[7:0];
      in_item.abs_x     <= s_tdata[23:8];
      in_item.abs_y     <= s_tdata[39:24];
      in_item.abs_left  <= s_tdata[40];
      in_item.abs_right <= s_tdata[41];
    end
  end

  mpt_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .item          (in_item),
    .ctrl          (ctrl),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .ps2_bytes     (ps2_bytes),
    .serial_bytes  (serial_bytes),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .ctrl_next     (ctrl_next),
    .cursor_x_next (cursor_x_next),
    .cursor_y_next (cursor_y_next),
    .byte_wr       (byte_wr),
    .has_result    (step_has_result),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= CURSOR_X_RESET;
      cursor_y <= CURSOR_Y_RESET;
      ctrl     <= '0;
    end else if (in_adv) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      ctrl     <= ctrl_next;
    end
  end

  // Packet byte stores are always written before they are read.
  always_ff @(posedge clk) begin
    if (in_adv && byte_wr.ps2_we) begin
      ps2_bytes[byte_wr.idx] <= in_item.data_byte;
    end
    if (in_adv && byte_wr.serial_we) begin
      serial_bytes[byte_wr.idx] <= in_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_adv && step_has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && step_has_result) begin
      out_res <= step_result;
    end
  end

  assign m_tdata = {out_res.pos_y, out_res.pos_x};
  assign m_tuser = 2'(out_res.event_kind);

  // A stalled result must never be overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(in_adv && step_has_result))
    else $error("result register overwritten while stalled");

  // An accepted request is always held in the input register next cycle.
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted request not captured");

  // Recenter never produces a result.
  a_recenter_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_item.action == ACT_RECENTER) |-> !step_has_result)
    else $error("recenter produced a result");

  // Packet assemblers never hold more than two bytes.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    in_adv |=> (ctrl.ps2_count != 2'd3) && (ctrl.serial_count != 2'd3))
    else $error("packet byte count out of range");

endmodule

`default_nettype wire

// ----- tb/mouse_packet_pointer_tracker_test.sv -----
// Self-checking testbench for the mouse packet pointer tracker.
// Depends on mpt_pkg, mpt_step and the mouse_packet_pointer_tracker RTL; needs no other file.
`timescale 1ns / 1ps

// The bench drives requests into the slave stream and predicts each result with
// its own copy of the tracker state: both packet assemblers, the button state,
// the pointer and the screen size registers. Predicted results wait in a queue
// in the scoreboard, and each result taken from the master stream is compared
// field by field with the oldest one. The run starts with a short directed part
// at the reset screen size. Random traffic then follows over several screen
// sizes, the extremes among them. Most of that traffic is well-formed PS/2 and
// serial packets with random content; the rest is absolute reports, recenter
// commands, stray bytes and cut-off packets.
module mouse_packet_pointer_tracker_test;
  import mpt_pkg::*;

  localparam int POS_MAX     = (1 << PTR_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER  = 150;   // results taken before the long sink stall
  localparam int HOLD_CYCLES = 500;

  // Indexes that address no register; the tracker must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // The scoreboard keeps the predicted tracker state and the queue of results
  // that are still to come from the block.
  class tracker_scoreboard;
    int unsigned width_limit;
    int unsigned height_limit;
    int cur_x;
    int cur_y;
    bit left_held;
    bit right_held;
    int ps2_count;
    int serial_count;
    logic [7:0] ps2_bytes[2];
    logic [7:0] serial_bytes[2];
    mpt_result_t pending_events[$];
    int failures;

    function new();
      width_limit  = SCREEN_WIDTH_RESET;
      height_limit = SCREEN_HEIGHT_RESET;
      cur_x = center_of(width_limit);
      cur_y = center_of(height_limit);
      left_held = 1'b0;
      right_held = 1'b0;
      ps2_count = 0;
      serial_count = 0;
      failures = 0;
    endfunction

    function int clamp_to(int v, int unsigned size);
      int lim;
      lim = (size == 0) ? 0 : int'(size) - 1;
      if (lim > POS_MAX) lim = POS_MAX;
      if (v > lim) v = lim;
      if (v < 0) v = 0;
      return v;
    endfunction

    function int center_of(int unsigned size);
      int h;
      h = int'(size / 2);
      return (h > POS_MAX) ? POS_MAX : h;
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
      if (idx == CFG_SCREEN_WIDTH) begin
        width_limit = 32'(value);
      end else if (idx == CFG_SCREEN_HEIGHT) begin
        height_limit = 32'(value);
      end
    endfunction

    // Moves the pointer and works out the button event. The position and the
    // buttons are stored even when the move gives no result.
    function void move_to(int x, int y, bit left, bit right);
      mpt_event_t kind;
      mpt_result_t r;
      bit same;
      x = clamp_to(x, width_limit);
      y = clamp_to(y, height_limit);
      kind = EV_MOVE;
      if (left && !left_held) begin
        kind = EV_LEFT_DOWN;
      end else if (!left && left_held) begin
        kind = EV_LEFT_UP;
      end else if (right && !right_held) begin
        kind = EV_RIGHT_DOWN;
      end
      same = (x == cur_x) && (y == cur_y);
      cur_x = x;
      cur_y = y;
      left_held = left;
      right_held = right;
      if (kind != EV_MOVE || !same) begin
        r.event_kind = kind;
        r.pos_x = x[PTR_W-1:0];
        r.pos_y = y[PTR_W-1:0];
        pending_events.push_back(r);
      end
    endfunction

    // A serial packet restarts on any byte with bit 6 set; deltas are 8 bits
    // and y grows downward as sent.
    function void serial_step(logic [7:0] b);
      logic [7:0] p0;
      logic [7:0] p1;
      logic signed [7:0] d8x;
      logic signed [7:0] d8y;
      if (b[6]) begin
        serial_count = 0;
      end else if (serial_count == 0) begin
        return;
      end
      if (serial_count < 2) begin
        serial_bytes[serial_count] = b;
        serial_count++;
        return;
      end
      serial_count = 0;
      p0 = serial_bytes[0];
      p1 = serial_bytes[1];
      d8x = {p0[1:0], p1[5:0]};
      d8y = {p0[3:2], b[5:0]};
      move_to(cur_x + int'(d8x), cur_y + int'(d8y), p0[5], p0[4]);
    endfunction

    // A PS/2 packet starts only on a byte with bit 3 set. It carries 9-bit
    // deltas, y points up, and a packet with an overflow bit is dropped.
    function void ps2_step(logic [7:0] b);
      logic [7:0] p0;
      logic [7:0] p1;
      int dx;
      int dy;
      if (ps2_count == 0 && !b[3]) return;
      if (ps2_count < 2) begin
        ps2_bytes[ps2_count] = b;
        ps2_count++;
        return;
      end
      ps2_count = 0;
      p0 = ps2_bytes[0];
      p1 = ps2_bytes[1];
      if (p0[7:6] != 2'b00) return;
      dx = int'(p1) - (p0[4] ? 256 : 0);
      dy = int'(b) - (p0[5] ? 256 : 0);
      move_to(cur_x + dx, cur_y - dy, p0[0], p0[1]);
    endfunction

    function void note_request(mpt_item_t it);
      logic signed [ABS_W-1:0] sx;
      logic signed [ABS_W-1:0] sy;
      case (it.action)
        ACT_PS2: begin
          ps2_step(it.data_byte);
        end
        ACT_SERIAL: begin
          serial_step(it.data_byte);
        end
        ACT_ABS: begin
          sx = it.abs_x;
          sy = it.abs_y;
          move_to(int'(sx), int'(sy), it.abs_left, it.abs_right);
        end
        default: begin
          cur_x = center_of(width_limit);
          cur_y = center_of(height_limit);
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [PTR_W-1:0] x, logic [PTR_W-1:0] y);
      mpt_result_t want;
      if (pending_events.size() == 0) begin
        $error("unexpected result: event_kind %0d pos_x %0d pos_y %0d", kind, x, y);
        failures++;
        return;
      end
      want = pending_events.pop_front();
      if (kind !== want.event_kind) begin
        $error("event_kind: expected %0d, got %0d", want.event_kind, kind);
        failures++;
      end
      if (x !== want.pos_x) begin
        $error("pos_x: expected %0d, got %0d", want.pos_x, x);
        failures++;
      end
      if (y !== want.pos_y) begin
        $error("pos_y: expected %0d, got %0d", want.pos_y, y);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SIZE_W-1:0]     cfg_data = '0;

  tracker_scoreboard book;
  bit calm = 1'b0;        // while set, neither side idles
  int cycles = 0;

  mouse_packet_pointer_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Every request carries random values in the fields its action does not use,
  // so those bits toggle too.
  function automatic mpt_item_t blank_item(mpt_action_t act);
    mpt_item_t it;
    it.action = act;
    it.data_byte = 8'($urandom);
    it.abs_x = ABS_W'($urandom);
    it.abs_y = ABS_W'($urandom);
    it.abs_left = 1'($urandom);
    it.abs_right = 1'($urandom);
    return it;
  endfunction

  // Mostly coordinates on or just past the screen, sometimes anything that
  // fits in 16 signed bits.
  function automatic logic [ABS_W-1:0] pick_coord(int unsigned size);
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return ABS_W'($urandom_range(0, size + 4));
    if (pick < 80) return ABS_W'(-int'($urandom_range(1, 40)));
    return ABS_W'($urandom);
  endfunction

  // Offers one request and returns once the tracker has taken it. The sender
  // idles at random before the request unless the calm stretch is on.
  task automatic send_request(input mpt_item_t it);
    while (!calm && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.action;
    s_tdata <= {6'b0, it.abs_right, it.abs_left, it.abs_y, it.abs_x, it.data_byte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_request(it);
  endtask

  task automatic send_byte(input mpt_action_t act, input logic [7:0] b);
    mpt_item_t it;
    it = blank_item(act);
    it.data_byte = b;
    send_request(it);
  endtask

  task automatic send_abs(input logic [ABS_W-1:0] x, input logic [ABS_W-1:0] y,
                          input logic left, input logic right);
    mpt_item_t it;
    it = blank_item(ACT_ABS);
    it.abs_x = x;
    it.abs_y = y;
    it.abs_left = left;
    it.abs_right = right;
    send_request(it);
  endtask

  // The config channel keeps valid high across back-to-back writes; the caller
  // lowers it once after the last one.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_size(idx, value);
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h, input bit spare);
    write_register(CFG_SCREEN_WIDTH, SIZE_W'(w));
    write_register(CFG_SCREEN_HEIGHT, SIZE_W'(h));
    if (spare) begin
      write_register(CFG_SPARE_LO, SIZE_W'($urandom));
      write_register(CFG_SPARE_HI, SIZE_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted result has arrived, then waits on so that
  // requests which give no result have left the pipeline too.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (book.pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Directed requests at the reset screen of 640 by 480.
  task automatic directed_checks();
    send_byte(ACT_RECENTER, 8'h00);
    // Press left at the top corner, then hold it while clamping from far off
    // screen, which leaves the pointer where it is and gives no result.
    send_abs(16'sd0, 16'sd0, 1'b1, 1'b0);
    send_abs(16'h8000, 16'h8000, 1'b1, 1'b0);
    // Release left and press right in one report at the far corner; the release wins.
    send_abs(16'h7FFF, 16'h7FFF, 1'b0, 1'b1);
    // A right release alone is a plain move; at the same spot it gives nothing.
    send_abs(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
    // A PS/2 byte without the sync bit is skipped while no packet is open.
    send_byte(ACT_PS2, 8'h00);
    // Negative deltas in both axes with left pressed.
    send_byte(ACT_PS2, 8'h39);
    send_byte(ACT_PS2, 8'hF0);
    send_byte(ACT_PS2, 8'hE0);
    // Overflow bits set: the whole packet is dropped.
    send_byte(ACT_PS2, 8'hCF);
    send_byte(ACT_PS2, 8'hFF);
    send_byte(ACT_PS2, 8'hFF);
    // Left release together with right press: the release wins.
    send_byte(ACT_PS2, 8'h0A);
    send_byte(ACT_PS2, 8'h7F);
    send_byte(ACT_PS2, 8'h80);
    // Serial packet with every delta bit set, so both deltas are -1.
    send_byte(ACT_SERIAL, 8'h4F);
    send_byte(ACT_SERIAL, 8'h3F);
    send_byte(ACT_SERIAL, 8'hBF);
    // A new sync byte in mid packet restarts the serial assembler.
    send_byte(ACT_SERIAL, 8'h40);
    send_byte(ACT_SERIAL, 8'h01);
    send_byte(ACT_SERIAL, 8'h73);
    send_byte(ACT_SERIAL, 8'h3F);
    send_byte(ACT_SERIAL, 8'h80);
    // A stray serial byte while no packet is open is skipped.
    send_byte(ACT_SERIAL, 8'h3F);
  endtask

  // Random traffic: mostly whole packets with random content, some of them cut
  // short, plus absolute reports, recenters and stray bytes.
  task automatic run_traffic(input int count);
    int sent;
    int pick;
    int len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    mpt_action_t act;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      len = ($urandom_range(99) < 8) ? $urandom_range(1, 2) : 3;
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      if (pick < 35) begin
        b0 = 8'($urandom);
        b0[3] = 1'b1;
        if ($urandom_range(99) < 85) b0[7:6] = 2'b00;
        act = ACT_PS2;
      end else if (pick < 65) begin
        b0 = 8'($urandom);
        b0[6] = 1'b1;
        b1[6] = 1'b0;
        b2[6] = 1'b0;
        act = ACT_SERIAL;
      end
      if (pick < 65) begin
        send_byte(act, b0);
        if (len > 1) send_byte(act, b1);
        if (len > 2) send_byte(act, b2);
        sent += len;
      end else if (pick < 85) begin
        send_abs(pick_coord(book.width_limit), pick_coord(book.height_limit),
                 1'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 90) begin
        send_request(blank_item(ACT_RECENTER));
        sent++;
      end else begin
        act = $urandom_range(1) ? ACT_SERIAL : ACT_PS2;
        send_byte(act, 8'($urandom));
        sent++;
      end
    end
  endtask

  // Result sink: takes results with random stalls, and once holds off for a
  // long stretch so that the output register stays full and the input stalls.
  initial begin : result_sink
    int taken;
    int hold;
    taken = 0;
    hold = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 19);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        book.check_result(m_tuser, m_tdata[PTR_W-1:0], m_tdata[2*PTR_W-1:PTR_W]);
        taken++;
        if (taken == HOLD_AFTER) hold = HOLD_CYCLES;
      end
    end
  end

  // Screen sizes for the phases after the reset phase: the smallest, the
  // largest in range, zero, the largest the register holds, a lopsided one,
  // a random one, and the reset size again.
  initial begin : stimulus
    int unsigned phase_width[7];
    int unsigned phase_height[7];
    book = new();
    phase_width  = '{1, 4096, 0, 8191, 4097, 0, SCREEN_WIDTH_RESET};
    phase_height = '{1, 4096, 0, 8191, 2, 0, SCREEN_HEIGHT_RESET};
    phase_width[5]  = $urandom_range(1, 4096);
    phase_height[5] = $urandom_range(1, 4096);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();
    run_traffic(200);
    settle();
    for (int p = 0; p < 7; p++) begin
      set_screen(phase_width[p], phase_height[p], p == 3);
      // The phase on the largest screen in range runs with no idling on either side.
      calm = (p == 1);
      run_traffic(225);
      settle();
    end
    if (book.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
